>>> rtl/bdlpr_pkg.sv
package bdlpr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;
    localparam int ENABLE_W    = 3;
    localparam int INDEX_W     = 4;
    localparam int ACT_W       = 3;
    localparam int TIME_IN_W   = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_ENABLE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_RATE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_CAPABLE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_MASK   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [ENABLE_W-1:0] RST_EVENT_ENABLE = 3'd7;
    localparam logic [MS_W-1:0]     RST_DEBOUNCE     = 16'd50;
    localparam logic [MS_W-1:0]     RST_LONG_PRESS   = 16'd500;
    localparam logic [MS_W-1:0]     RST_REPEAT_DELAY = 16'd400;
    localparam logic [MS_W-1:0]     RST_REPEAT_RATE  = 16'd100;
    localparam int                  RST_LONG_CAPABLE = 103;
    localparam int                  RST_REPEAT_MASK  = 408;

    // Bits of the event enable register.
    localparam int EN_PRESS_BIT   = 0;
    localparam int EN_RELEASE_BIT = 1;
    localparam int EN_LONG_BIT    = 2;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2
    } event_kind_t;

    localparam logic [ACT_W-1:0] ACT_QUEUE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SETTINGS = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BROWSE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MENU     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_HOME     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic push;
        logic ptr_inc;
        logic next_key;
        logic flush;
    } bdlpr_cmd_t;

    typedef struct packed {
        logic has_events;
        logic last_key;
        logic ptr_last;
        logic push_ok;
        logic pend_valid;
        logic slot_free;
    } bdlpr_status_t;

    // Long-press action of each button; buttons without a named action map to queue.
    function automatic logic [ACT_W-1:0] long_action_of(input logic [4:0] key);
        logic [ACT_W-1:0] act;
        act = ACT_QUEUE;
        case (key)
            5'd1:    act = ACT_SETTINGS;
            5'd2:    act = ACT_BROWSE;
            5'd5:    act = ACT_MENU;
            5'd6:    act = ACT_HOME;
            default: act = ACT_QUEUE;
        endcase
        return act;
    endfunction

endpackage

>>> rtl/bdlpr_ctrl.sv
module bdlpr_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  bdlpr_pkg::bdlpr_status_t status,
    output bdlpr_pkg::bdlpr_cmd_t    cmd
);

    bdlpr_pkg::ctrl_state_t state_reg;
    bdlpr_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdlpr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdlpr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bdlpr_pkg::ST_EVAL;
                end
            end
            bdlpr_pkg::ST_EVAL:
            begin
                if (status.has_events)
                begin
                    state_next = bdlpr_pkg::ST_DRAIN;
                end
                else if (status.last_key)
                begin
                    state_next = bdlpr_pkg::ST_FINISH;
                end
            end
            bdlpr_pkg::ST_DRAIN:
            begin
                if (status.push_ok && status.ptr_last)
                begin
                    state_next = status.last_key ? bdlpr_pkg::ST_FINISH : bdlpr_pkg::ST_EVAL;
                end
            end
            bdlpr_pkg::ST_FINISH:
            begin
                if (!status.pend_valid || status.slot_free)
                begin
                    state_next = bdlpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdlpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            bdlpr_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            bdlpr_pkg::ST_EVAL:
            begin
                cmd.eval     = 1'b1;
                cmd.next_key = !status.has_events && !status.last_key;
            end
            bdlpr_pkg::ST_DRAIN:
            begin
                cmd.push     = status.push_ok;
                cmd.ptr_inc  = status.push_ok && !status.ptr_last;
                cmd.next_key = status.push_ok && status.ptr_last && !status.last_key;
            end
            bdlpr_pkg::ST_FINISH:
            begin
                cmd.flush = status.pend_valid && status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/bdlpr_datapath.sv
module bdlpr_datapath
#(
    parameter int NUM_KEYS  = 9,
    parameter int TIME_BITS = 32,
    parameter int KEY_W     = 4
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bdlpr_pkg::bdlpr_cmd_t                   cmd,
    output bdlpr_pkg::bdlpr_status_t                status,
    input  logic [bdlpr_pkg::TIME_IN_W-1:0]         time_ms,
    input  logic [NUM_KEYS-1:0]                     pin_levels,
    input  logic                                    cfg_valid,
    input  logic [bdlpr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [bdlpr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                    out_stall,
    output logic                                    out_valid,
    output logic [1:0]                              event_kind,
    output logic [bdlpr_pkg::INDEX_W-1:0]           button_index,
    output logic [bdlpr_pkg::ACT_W-1:0]             long_action,
    output logic                                    last_event
);

    localparam int MS_W  = bdlpr_pkg::MS_W;
    localparam int ACT_W = bdlpr_pkg::ACT_W;

    // Configuration registers.
    logic [bdlpr_pkg::ENABLE_W-1:0] enable_reg;
    logic [MS_W-1:0]                debounce_reg;
    logic [MS_W-1:0]                long_press_reg;
    logic [MS_W-1:0]                repeat_delay_reg;
    logic [MS_W-1:0]                repeat_rate_reg;
    logic [NUM_KEYS-1:0]            lcap_mask_reg;
    logic [NUM_KEYS-1:0]            repeat_mask_reg;

    // Per-button state.
    logic [NUM_KEYS-1:0]  pressed_reg;
    logic [NUM_KEYS-1:0]  long_fired_reg;
    logic [TIME_BITS-1:0] press_stamp_reg  [NUM_KEYS];
    logic [TIME_BITS-1:0] repeat_stamp_reg [NUM_KEYS];

    // Poll being worked on.
    logic [TIME_BITS-1:0] now_reg;
    logic [NUM_KEYS-1:0]  levels_reg;
    logic [KEY_W-1:0]     key_reg;

    // Events of the current button, at most two.
    bdlpr_pkg::event_kind_t ev0_kind_reg;
    bdlpr_pkg::event_kind_t ev1_kind_reg;
    logic [ACT_W-1:0]       ev0_act_reg;
    logic [ACT_W-1:0]       ev1_act_reg;
    logic                   ev_two_reg;
    logic                   ev_ptr_reg;

    // One-event lookahead so that the last event of a poll can be flagged.
    logic                   pend_valid_reg;
    bdlpr_pkg::event_kind_t pend_kind_reg;
    logic [KEY_W-1:0]       pend_key_reg;
    logic [ACT_W-1:0]       pend_act_reg;

    // Output register.
    logic                   out_valid_reg;
    bdlpr_pkg::event_kind_t out_kind_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic [ACT_W-1:0]       out_act_reg;
    logic                   out_last_reg;

    // Evaluation of one button.
    logic                   raw;
    logic                   lcap;
    logic                   rep;
    logic                   pf;
    logic                   lf;
    logic                   lf1;
    logic [TIME_BITS-1:0]   ps;
    logic [TIME_BITS-1:0]   rs;
    logic [TIME_BITS-1:0]   ps_n;
    logic [TIME_BITS-1:0]   rs1;
    logic [TIME_BITS-1:0]   rs_n;
    logic [TIME_BITS-1:0]   d_press;
    logic [TIME_BITS-1:0]   d_long;
    logic [TIME_BITS-1:0]   d_rep;
    logic [MS_W-1:0]        wait_ms;
    logic                   chg;
    logic                   go_down;
    logic                   go_up;
    logic                   pf_n;
    logic                   lf_n;
    logic                   fire_long;
    logic                   fire_rep;
    logic                   c0;
    logic                   c1;
    logic                   c2;
    bdlpr_pkg::event_kind_t c2_kind;
    logic [ACT_W-1:0]       c2_act;
    logic [ACT_W-1:0]       key_act;
    bdlpr_pkg::event_kind_t ev0_kind;
    bdlpr_pkg::event_kind_t ev1_kind;
    logic [ACT_W-1:0]       ev0_act;
    logic [ACT_W-1:0]       ev1_act;
    bdlpr_pkg::event_kind_t head_kind;
    logic [ACT_W-1:0]       head_act;
    logic                   en_press;
    logic                   en_rel;
    logic                   en_long;
    logic                   slot_free;
    logic                   load_out;

    assign en_press = enable_reg[bdlpr_pkg::EN_PRESS_BIT];
    assign en_rel   = enable_reg[bdlpr_pkg::EN_RELEASE_BIT];
    assign en_long  = enable_reg[bdlpr_pkg::EN_LONG_BIT];

    always_comb
    begin
        raw     = !levels_reg[key_reg];
        lcap    = lcap_mask_reg[key_reg];
        rep     = repeat_mask_reg[key_reg];
        pf      = pressed_reg[key_reg];
        lf      = long_fired_reg[key_reg];
        ps      = press_stamp_reg[key_reg];
        rs      = repeat_stamp_reg[key_reg];
        key_act = bdlpr_pkg::long_action_of(5'(key_reg));

        // A level change must wait out the debounce time since the last press.
        d_press = now_reg - ps;
        chg     = (raw != pf) && (d_press > TIME_BITS'(debounce_reg));
        go_down = chg && raw;
        go_up   = chg && !raw;
        pf_n    = chg ? raw : pf;
        ps_n    = go_down ? now_reg : ps;
        rs1     = go_down ? now_reg : rs;
        lf1     = go_down ? 1'b0 : lf;

        // A fresh press restamps both times, so both elapsed times are zero.
        d_long    = go_down ? '0 : d_press;
        fire_long = pf_n && !lf1 && lcap && (d_long >= TIME_BITS'(long_press_reg));
        lf_n      = lf1 || fire_long;

        wait_ms  = (rs1 == ps_n) ? repeat_delay_reg : repeat_rate_reg;
        d_rep    = go_down ? '0 : (now_reg - rs);
        fire_rep = pf_n && !lcap && rep && (d_rep >= TIME_BITS'(wait_ms));
        rs_n     = fire_rep ? now_reg : rs1;

        c0      = (go_down && !lcap && en_press) || (go_up && !lf && lcap && en_press);
        c1      = go_up && en_rel;
        c2      = (fire_long && en_long) || (fire_rep && en_press);
        c2_kind = fire_long ? bdlpr_pkg::EV_LONG : bdlpr_pkg::EV_PRESS;
        c2_act  = fire_long ? key_act : bdlpr_pkg::ACT_QUEUE;

        // A release ends the hold, so c1 and c2 never come together.
        if (c0)
        begin
            ev0_kind = bdlpr_pkg::EV_PRESS;
            ev0_act  = bdlpr_pkg::ACT_QUEUE;
        end
        else if (c1)
        begin
            ev0_kind = bdlpr_pkg::EV_RELEASE;
            ev0_act  = bdlpr_pkg::ACT_QUEUE;
        end
        else
        begin
            ev0_kind = c2_kind;
            ev0_act  = c2_act;
        end
        ev1_kind = c1 ? bdlpr_pkg::EV_RELEASE : c2_kind;
        ev1_act  = c1 ? bdlpr_pkg::ACT_QUEUE : c2_act;

        head_kind = ev_ptr_reg ? ev1_kind_reg : ev0_kind_reg;
        head_act  = ev_ptr_reg ? ev1_act_reg : ev0_act_reg;
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign load_out  = (cmd.push && pend_valid_reg) || cmd.flush;

    always_comb
    begin
        status.has_events = c0 || c1 || c2;
        status.last_key   = (key_reg == KEY_W'(NUM_KEYS - 1));
        status.ptr_last   = ev_ptr_reg || !ev_two_reg;
        status.push_ok    = !pend_valid_reg || slot_free;
        status.pend_valid = pend_valid_reg;
        status.slot_free  = slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= bdlpr_pkg::RST_EVENT_ENABLE;
            debounce_reg     <= bdlpr_pkg::RST_DEBOUNCE;
            long_press_reg   <= bdlpr_pkg::RST_LONG_PRESS;
            repeat_delay_reg <= bdlpr_pkg::RST_REPEAT_DELAY;
            repeat_rate_reg  <= bdlpr_pkg::RST_REPEAT_RATE;
            lcap_mask_reg    <= NUM_KEYS'(bdlpr_pkg::RST_LONG_CAPABLE);
            repeat_mask_reg  <= NUM_KEYS'(bdlpr_pkg::RST_REPEAT_MASK);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bdlpr_pkg::CFG_EVENT_ENABLE: enable_reg       <= cfg_data[bdlpr_pkg::ENABLE_W-1:0];
                bdlpr_pkg::CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                bdlpr_pkg::CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                bdlpr_pkg::CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                bdlpr_pkg::CFG_REPEAT_RATE:  repeat_rate_reg  <= cfg_data;
                bdlpr_pkg::CFG_LONG_CAPABLE: lcap_mask_reg    <= NUM_KEYS'(cfg_data);
                bdlpr_pkg::CFG_REPEAT_MASK:  repeat_mask_reg  <= NUM_KEYS'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg    <= '0;
            long_fired_reg <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                press_stamp_reg[k]  <= '0;
                repeat_stamp_reg[k] <= '0;
            end
        end
        else if (cmd.eval)
        begin
            pressed_reg[key_reg]      <= pf_n;
            long_fired_reg[key_reg]   <= lf_n;
            press_stamp_reg[key_reg]  <= ps_n;
            repeat_stamp_reg[key_reg] <= rs_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg        <= '0;
            ev_ptr_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                key_reg <= '0;
            end
            else if (cmd.next_key)
            begin
                key_reg <= key_reg + KEY_W'(1);
            end

            if (cmd.eval)
            begin
                ev_ptr_reg <= 1'b0;
            end
            else if (cmd.ptr_inc)
            begin
                ev_ptr_reg <= 1'b1;
            end

            if (cmd.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg    <= TIME_BITS'(time_ms);
            levels_reg <= pin_levels;
        end
        if (cmd.eval)
        begin
            ev0_kind_reg <= ev0_kind;
            ev0_act_reg  <= ev0_act;
            ev1_kind_reg <= ev1_kind;
            ev1_act_reg  <= ev1_act;
            ev_two_reg   <= c0 && (c1 || c2);
        end
        if (cmd.push)
        begin
            pend_kind_reg <= head_kind;
            pend_key_reg  <= key_reg;
            pend_act_reg  <= head_act;
        end
        if (load_out)
        begin
            out_kind_reg <= pend_kind_reg;
            out_key_reg  <= pend_key_reg;
            out_act_reg  <= pend_act_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_kind_reg;
    assign button_index = bdlpr_pkg::INDEX_W'(out_key_reg);
    assign long_action  = out_act_reg;
    assign last_event   = out_last_reg;

endmodule

>>> rtl/button_debounce_long_press_repeat_unit.sv
// Debounces NUM_KEYS active-low buttons and reports press, release and long-press
// events with auto-repeat. Each poll transaction carries a millisecond timestamp and the
// raw pin levels; the unit then walks the buttons in index order, one button per clock
// cycle while a button produces no event, and stops to push each event that a button
// produces before moving to the next button. Pushes wait while the result side stalls,
// and the next poll is taken once the previous one is finished. Results go out through an
// output register, and the final result of a poll is marked with last_event, which needs
// one event of lookahead. A poll that produces no event produces no result. Configuration
// writes are always ready and must only be issued while no poll is in progress.
module button_debounce_long_press_repeat_unit
#(
    parameter int NUM_KEYS  = 9,
    parameter int TIME_BITS = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bdlpr_pkg::TIME_IN_W-1:0]    time_ms,
    input  logic [NUM_KEYS-1:0]                pin_levels,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bdlpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bdlpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         event_kind,
    output logic [bdlpr_pkg::INDEX_W-1:0]      button_index,
    output logic [bdlpr_pkg::ACT_W-1:0]        long_action,
    output logic                               last_event
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    bdlpr_pkg::bdlpr_cmd_t    cmd;
    bdlpr_pkg::bdlpr_status_t status;

    assign cfg_ready = 1'b1;

    bdlpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bdlpr_datapath
    #(
        .NUM_KEYS  (NUM_KEYS),
        .TIME_BITS (TIME_BITS),
        .KEY_W     (KEY_W)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .time_ms      (time_ms),
        .pin_levels   (pin_levels),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .event_kind   (event_kind),
        .button_index (button_index),
        .long_action  (long_action),
        .last_event   (last_event)
    );

endmodule

>>> rtl/bdlpr_checker.sv
module bdlpr_checker
#(
    parameter int NUM_KEYS = 9
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    event_kind,
    input logic [bdlpr_pkg::INDEX_W-1:0] button_index,
    input logic [bdlpr_pkg::ACT_W-1:0]   long_action,
    input logic                          last_event
);

    // The unit works on one poll at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("poll accepted while the previous one was still in progress");

    // Between polls only the final result of the previous poll may still wait.
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_stall) |-> last_event)
        else $error("unit idle while a non-final result is pending");

    a_action_only_long: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind != bdlpr_pkg::EV_LONG)) |-> (long_action == bdlpr_pkg::ACT_QUEUE))
        else $error("long action set on a press or release event");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((32'(button_index) < NUM_KEYS) && (event_kind != 2'd3)))
        else $error("result carries an invalid button index or event kind");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(event_kind)
            && $stable(button_index) && $stable(long_action) && $stable(last_event)))
        else $error("stalled result changed");

endmodule

bind button_debounce_long_press_repeat_unit bdlpr_checker
#(
    .NUM_KEYS (NUM_KEYS)
)
u_bdlpr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .button_index (button_index),
    .long_action  (long_action),
    .last_event   (last_event)
);

>>> tb/button_debounce_long_press_repeat_unit_test.sv
module button_debounce_long_press_repeat_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS = 9;
    localparam int DRAIN_LIMIT = 100000;
    // Settling time after a drain, so that it covers a poll still in flight.
    localparam int POLL_SETTLE = 40;
    localparam logic [bdlpr_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct {
        bdlpr_pkg::event_kind_t           kind;
        logic [bdlpr_pkg::INDEX_W-1:0]    key;
        logic [bdlpr_pkg::ACT_W-1:0]      act;
        logic                             last;
    } key_event_t;

    typedef struct {
        logic [bdlpr_pkg::TIME_IN_W-1:0]  stamp;
        logic [KEYS-1:0]                  levels;
    } poll_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [bdlpr_pkg::TIME_IN_W-1:0]      time_ms = '0;
    logic [KEYS-1:0]                      pin_levels = '1;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [bdlpr_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [bdlpr_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [1:0]                           event_kind;
    logic [bdlpr_pkg::INDEX_W-1:0]        button_index;
    logic [bdlpr_pkg::ACT_W-1:0]          long_action;
    logic                                 last_event;

    // Predictor state and its copy of the registers.
    logic [bdlpr_pkg::ENABLE_W-1:0]       en_mask;
    logic [bdlpr_pkg::MS_W-1:0]           debounce;
    logic [bdlpr_pkg::MS_W-1:0]           hold_ms;
    logic [bdlpr_pkg::MS_W-1:0]           first_delay;
    logic [bdlpr_pkg::MS_W-1:0]           rate;
    logic [KEYS-1:0]                      long_keys;
    logic [KEYS-1:0]                      repeat_keys;
    logic                                 key_down [KEYS];
    logic                                 long_done [KEYS];
    logic [bdlpr_pkg::TIME_IN_W-1:0]      down_at [KEYS];
    logic [bdlpr_pkg::TIME_IN_W-1:0]      repeat_at [KEYS];

    key_event_t                           pending_events[$];
    poll_t                                polls_to_send[$];
    int                                   failures = 0;
    int                                   gap_left = 0;
    int                                   stall_left = 0;
    logic                                 quiet_in = 1'b0;
    logic                                 quiet_out = 1'b0;
    logic                                 hold_off = 1'b0;
    logic [bdlpr_pkg::TIME_IN_W-1:0]      sim_now = '0;
    logic [KEYS-1:0]                      sim_levels = '1;

    button_debounce_long_press_repeat_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .time_ms      (time_ms),
        .pin_levels   (pin_levels),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .button_index (button_index),
        .long_action  (long_action),
        .last_event   (last_event)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void clear_buttons();
        en_mask     = bdlpr_pkg::RST_EVENT_ENABLE;
        debounce    = bdlpr_pkg::RST_DEBOUNCE;
        hold_ms     = bdlpr_pkg::RST_LONG_PRESS;
        first_delay = bdlpr_pkg::RST_REPEAT_DELAY;
        rate        = bdlpr_pkg::RST_REPEAT_RATE;
        long_keys   = KEYS'(bdlpr_pkg::RST_LONG_CAPABLE);
        repeat_keys = KEYS'(bdlpr_pkg::RST_REPEAT_MASK);
        for (int k = 0; k < KEYS; k++)
        begin
            key_down[k]  = 1'b0;
            long_done[k] = 1'b0;
            down_at[k]   = '0;
            repeat_at[k] = '0;
        end
    endfunction

    function automatic void set_register(input logic [bdlpr_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [bdlpr_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            bdlpr_pkg::CFG_EVENT_ENABLE: en_mask     = value[bdlpr_pkg::ENABLE_W-1:0];
            bdlpr_pkg::CFG_DEBOUNCE:     debounce    = value;
            bdlpr_pkg::CFG_LONG_PRESS:   hold_ms     = value;
            bdlpr_pkg::CFG_REPEAT_DELAY: first_delay = value;
            bdlpr_pkg::CFG_REPEAT_RATE:  rate        = value;
            bdlpr_pkg::CFG_LONG_CAPABLE: long_keys   = value[KEYS-1:0];
            bdlpr_pkg::CFG_REPEAT_MASK:  repeat_keys = value[KEYS-1:0];
            default:                     ;
        endcase
    endfunction

    function automatic void push_event(input bdlpr_pkg::event_kind_t kind, input int k,
                                       input logic [bdlpr_pkg::ACT_W-1:0] act);
        key_event_t ev;
        ev.kind = kind;
        ev.key  = bdlpr_pkg::INDEX_W'(k);
        ev.act  = act;
        ev.last = 1'b0;
        pending_events.push_back(ev);
    endfunction

    // Walks the buttons in order and queues the events this poll should produce.
    function automatic void poll_buttons(input logic [bdlpr_pkg::TIME_IN_W-1:0] now,
                                         input logic [KEYS-1:0] lv);
        key_event_t tail;
        logic down;
        logic lcap;
        logic [bdlpr_pkg::TIME_IN_W-1:0] since_down;
        logic [bdlpr_pkg::TIME_IN_W-1:0] since_repeat;
        logic [bdlpr_pkg::MS_W-1:0] wait_ms;
        logic [bdlpr_pkg::ACT_W-1:0] act;
        int n;
        n = 0;
        for (int k = 0; k < KEYS; k++)
        begin
            down = !lv[k];
            lcap = long_keys[k];
            case (k)
                1:       act = bdlpr_pkg::ACT_SETTINGS;
                2:       act = bdlpr_pkg::ACT_BROWSE;
                5:       act = bdlpr_pkg::ACT_MENU;
                6:       act = bdlpr_pkg::ACT_HOME;
                default: act = bdlpr_pkg::ACT_QUEUE;
            endcase
            since_down = now - down_at[k];
            if (down != key_down[k] && since_down > {16'd0, debounce})
            begin
                key_down[k] = down;
                if (down)
                begin
                    down_at[k]   = now;
                    long_done[k] = 1'b0;
                    repeat_at[k] = now;
                    if (!lcap && en_mask[bdlpr_pkg::EN_PRESS_BIT])
                    begin
                        push_event(bdlpr_pkg::EV_PRESS, k, bdlpr_pkg::ACT_QUEUE);
                        n++;
                    end
                end
                else
                begin
                    // A long-capable button reports its short press on release.
                    if (!long_done[k] && lcap && en_mask[bdlpr_pkg::EN_PRESS_BIT])
                    begin
                        push_event(bdlpr_pkg::EV_PRESS, k, bdlpr_pkg::ACT_QUEUE);
                        n++;
                    end
                    if (en_mask[bdlpr_pkg::EN_RELEASE_BIT])
                    begin
                        push_event(bdlpr_pkg::EV_RELEASE, k, bdlpr_pkg::ACT_QUEUE);
                        n++;
                    end
                end
            end
            since_down = now - down_at[k];
            if (key_down[k] && !long_done[k] && lcap && since_down >= {16'd0, hold_ms})
            begin
                long_done[k] = 1'b1;
                if (en_mask[bdlpr_pkg::EN_LONG_BIT])
                begin
                    push_event(bdlpr_pkg::EV_LONG, k, act);
                    n++;
                end
            end
            if (key_down[k] && !lcap && repeat_keys[k])
            begin
                wait_ms = (repeat_at[k] == down_at[k]) ? first_delay : rate;
                since_repeat = now - repeat_at[k];
                if (since_repeat >= {16'd0, wait_ms})
                begin
                    repeat_at[k] = now;
                    if (en_mask[bdlpr_pkg::EN_PRESS_BIT])
                    begin
                        push_event(bdlpr_pkg::EV_PRESS, k, bdlpr_pkg::ACT_QUEUE);
                        n++;
                    end
                end
            end
        end
        if (n > 0)
        begin
            tail = pending_events.pop_back();
            tail.last = 1'b1;
            pending_events.push_back(tail);
        end
    endfunction

    // Poll driver.
    always @(posedge clk or negedge rst_n)
    begin
        poll_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            clear_buttons();
        end
        else
        begin
            if (in_valid && !in_stall)
                poll_buttons(time_ms, pin_levels);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (polls_to_send.size() > 0)
                begin
                    nxt = polls_to_send.pop_front();
                    in_valid   <= 1'b1;
                    time_ms    <= nxt.stamp;
                    pin_levels <= nxt.levels;
                    if (!quiet_in && $urandom_range(0, 99) < 25)
                        gap_left <= idle_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            set_register(cfg_index, cfg_data);
    end

    // Event monitor and result-side stall.
    always @(posedge clk or negedge rst_n)
    begin
        key_event_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("unexpected transaction: event_kind %0d button_index %0d",
                           event_kind, button_index);
                    failures++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                    begin
                        $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                        failures++;
                    end
                    if (button_index !== want.key)
                    begin
                        $error("button_index: expected %0d, got %0d", want.key, button_index);
                        failures++;
                    end
                    if (long_action !== want.act)
                    begin
                        $error("long_action: expected %0d, got %0d", want.act, long_action);
                        failures++;
                    end
                    if (last_event !== want.last)
                    begin
                        $error("last_event: expected %0d, got %0d", want.last, last_event);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (hold_off)
            begin
                out_stall <= 1'b1;
            end
            else if (!quiet_out && $urandom_range(0, 99) < 20)
            begin
                out_stall  <= 1'b1;
                stall_left <= idle_len() - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [bdlpr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bdlpr_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_regs(input logic [bdlpr_pkg::CFG_DATA_W-1:0] ev,
                             input logic [bdlpr_pkg::CFG_DATA_W-1:0] deb,
                             input logic [bdlpr_pkg::CFG_DATA_W-1:0] lp,
                             input logic [bdlpr_pkg::CFG_DATA_W-1:0] rd,
                             input logic [bdlpr_pkg::CFG_DATA_W-1:0] rr,
                             input logic [bdlpr_pkg::CFG_DATA_W-1:0] lc,
                             input logic [bdlpr_pkg::CFG_DATA_W-1:0] rm);
        write_reg(bdlpr_pkg::CFG_EVENT_ENABLE, ev);
        write_reg(bdlpr_pkg::CFG_DEBOUNCE, deb);
        write_reg(bdlpr_pkg::CFG_LONG_PRESS, lp);
        write_reg(bdlpr_pkg::CFG_REPEAT_DELAY, rd);
        write_reg(bdlpr_pkg::CFG_REPEAT_RATE, rr);
        write_reg(bdlpr_pkg::CFG_LONG_CAPABLE, lc);
        write_reg(bdlpr_pkg::CFG_REPEAT_MASK, rm);
        // The spare index must leave every register untouched.
        write_reg(CFG_SPARE, bdlpr_pkg::CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    task automatic add_poll(input logic [bdlpr_pkg::TIME_IN_W-1:0] stamp,
                            input logic [KEYS-1:0] levels);
        poll_t p;
        p.stamp  = stamp;
        p.levels = levels;
        polls_to_send.push_back(p);
    endtask

    function automatic logic [bdlpr_pkg::CFG_DATA_W-1:0] pick_ms();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return bdlpr_pkg::CFG_DATA_W'($urandom());
        return bdlpr_pkg::CFG_DATA_W'($urandom_range(1, 200));
    endfunction

    // Mostly holds and toggles of a few buttons, with time steps placed around the
    // configured thresholds; the rest is noise.
    task automatic add_random_polls(input int count);
        int r;
        logic [bdlpr_pkg::TIME_IN_W-1:0] step;
        for (int j = 0; j < count; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                step = '0;
            else if (r < 40)
                step = $urandom_range(1, 30);
            else if (r < 55)
                step = debounce + $urandom_range(0, 2);
            else if (r < 65)
                step = hold_ms + $urandom_range(0, 2) - 1;
            else if (r < 75)
                step = first_delay + $urandom_range(0, 2) - 1;
            else if (r < 85)
                step = rate + $urandom_range(0, 2) - 1;
            else if (r < 95)
                step = $urandom_range(31, 1000);
            else
                step = $urandom();
            sim_now = sim_now + step;
            r = $urandom_range(0, 99);
            if (r < 40)
                sim_levels = sim_levels;
            else if (r < 80)
                sim_levels = sim_levels ^ KEYS'($urandom() & $urandom());
            else if (r < 86)
                sim_levels = '0;
            else if (r < 92)
                sim_levels = '1;
            else
                sim_levels = KEYS'($urandom());
            add_poll(sim_now, sim_levels);
        end
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        // Sampled at the falling edge, after the driver and the monitor have updated.
        while ((polls_to_send.size() != 0 || in_valid || pending_events.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_events.size() != 0)
        begin
            $error("%0d expected events never arrived", pending_events.size());
            failures++;
            pending_events.delete();
        end
        repeat (POLL_SETTLE) @(posedge clk);
    endtask

    task automatic pick_idling();
        quiet_in  <= ($urandom_range(0, 3) == 0);
        quiet_out <= ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: debounce gate, first repeat, rate, long press, short press
        // on release, all-ones time and wrap of the time difference.
        add_poll(32'd0, 9'h1FF);
        add_poll(32'd10, 9'h000);
        add_poll(32'd51, 9'h000);
        add_poll(32'd451, 9'h000);
        add_poll(32'd551, 9'h000);
        add_poll(32'd651, 9'h1FF);
        add_poll(32'd700, 9'h000);
        add_poll(32'd760, 9'h1FF);
        add_poll(32'hFFFF_FFFF, 9'h155);
        add_poll(32'h0000_0020, 9'h0AA);
        drain();

        // Every button long-capable and repeating: no repeats, short presses on
        // release give two events per button, unnamed buttons long-press to queue.
        pick_idling();
        load_regs(16'd7, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'h01FF, 16'h01FF);
        add_poll(32'hFFFF_FF00, 9'h1FF);
        add_poll(32'hFFFF_FFF0, 9'h000);
        add_poll(32'h0000_0005, 9'h1FF);
        add_poll(32'h0000_0010, 9'h000);
        add_poll(32'h0001_000F, 9'h000);
        add_poll(32'h0001_0010, 9'h1FF);
        drain();

        // All event kinds disabled: state still moves, nothing comes out.
        load_regs(16'd0, 16'd1, 16'd2, 16'd3, 16'd1, 16'h00F0, 16'h010F);
        add_poll(32'h0002_0000, 9'h000);
        add_poll(32'h0002_0010, 9'h000);
        add_poll(32'h0002_0020, 9'h1FF);
        drain();

        // Back pressure: the result side holds off while polls keep coming.
        quiet_in <= 1'b1;
        load_regs(16'd7, 16'd0, 16'd3, 16'd2, 16'd1, 16'h00F0, 16'h010F);
        sim_now = 32'h0003_0000;
        for (int j = 0; j < 30; j++)
        begin
            sim_now = sim_now + 5;
            add_poll(sim_now, (j % 2 == 0) ? 9'h000 : 9'h1FF);
        end
        hold_off <= 1'b1;
        repeat (500) @(posedge clk);
        hold_off <= 1'b0;
        drain();

        // No long-capable buttons, all repeating with a first delay and a rate of 1 ms.
        pick_idling();
        load_regs(16'd7, 16'd0, pick_ms(), 16'd1, 16'd1, 16'h0000, 16'h01FF);
        sim_now = $urandom();
        add_random_polls(35);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            pick_idling();
            load_regs(($urandom_range(0, 3) == 0) ?
                          bdlpr_pkg::CFG_DATA_W'($urandom_range(0, 7)) : 16'd7,
                      pick_ms(), pick_ms(), pick_ms(), pick_ms(),
                      bdlpr_pkg::CFG_DATA_W'($urandom_range(0, 511)),
                      bdlpr_pkg::CFG_DATA_W'($urandom_range(0, 511)));
            sim_now = $urandom();
            add_random_polls(30);
            drain();
        end

        if (failures == 0)
            $display("button_debounce_long_press_repeat_unit_test: PASS");
        else
            $display("button_debounce_long_press_repeat_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("button_debounce_long_press_repeat_unit_test: FAIL");
        $finish;
    end

endmodule
